[hw/rtl/r5xor_pkg.sv]
// Package for the RAID-5 XOR parity engine.
// Holds the item structs, function codes, register indexes and reset values.
// Used by raid5_xor_parity_engine; depends on nothing.
`default_nettype none

package r5xor_pkg;

  localparam int unsigned FuncW   = 1;
  localparam int unsigned IdW     = 4;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned WordW   = 64;
  localparam int unsigned KW      = 4;
  localparam int unsigned CwW     = 11;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned NumIds  = 16;

  localparam logic [FuncW-1:0] FUNC_ABSORB = 1'b0;
  localparam logic [FuncW-1:0] FUNC_DRAIN  = 1'b1;

  localparam logic [CfgAddrW-1:0] CFG_DATA_CHUNKS = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_CHUNK_WORDS = 1'b1;

  localparam logic [KW-1:0]  DATA_CHUNKS_RST = 4'd4;
  localparam logic [CwW-1:0] CHUNK_WORDS_RST = 11'd1024;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   chunk_id;
    logic [IdxW-1:0]  word_index;
    logic [WordW-1:0] data_word;
  } req_item_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [IdxW-1:0]  result_index;
    logic             last_word;
    logic [IdW-1:0]   missing_chunk;
    logic             missing_valid;
  } rsp_item_t;

endpackage

`default_nettype wire

[hw/rtl/raid5_xor_parity_engine.sv]
// Top level of the RAID-5 XOR parity engine: word buffer, mask and result queue.
// Depends on r5xor_pkg for item structs, codes and reset values.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | r5xor_pkg::req_item_t
//   rsp     | out       | rsp_valid/rsp_ready  | r5xor_pkg::rsp_item_t
//   cfg     | in        | cfg_we               | cfg_addr, cfg_wdata
//
// One item per cycle while req_ready is high; a drain result is registered in s1,
// then in the result queue. The buffer is one memory with a registered read; a
// read-modify-write of the same word in consecutive cycles is served from a
// write-back bypass register. After reset all CHUNK_DEPTH words are cleared with
// req_ready low; else it drops only when the four-entry result queue could overflow.
`default_nettype none

module raid5_xor_parity_engine #(
  parameter int unsigned CHUNK_DEPTH = 1024,
  parameter int unsigned MAX_CHUNKS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire r5xor_pkg::req_item_t             req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output r5xor_pkg::rsp_item_t                  rsp,
  input  wire logic                             cfg_we,
  input  wire logic [r5xor_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire logic [r5xor_pkg::CfgDataW-1:0]   cfg_wdata
);

  localparam int unsigned AW     = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int unsigned WideW  = 17;
  localparam int unsigned MaskW  = (MAX_CHUNKS < r5xor_pkg::NumIds) ?
                                   MAX_CHUNKS : r5xor_pkg::NumIds;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  logic [r5xor_pkg::KW-1:0]  data_chunks;
  logic [r5xor_pkg::CwW-1:0] chunk_words;

  logic [r5xor_pkg::WordW-1:0] mem [CHUNK_DEPTH];
  logic [r5xor_pkg::WordW-1:0] rdata;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [r5xor_pkg::WordW-1:0] mem_wdata;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic [MaskW-1:0] mask;
  logic [MaskW-1:0] mask_next;

  logic                              accept;
  logic [WideW-1:0]                  req_idx_wide;
  logic                              req_inrange;
  logic [AW-1:0]                     req_addr;
  logic                              req_last;
  logic [r5xor_pkg::NumIds-1:0]      seen;
  logic [r5xor_pkg::IdW-1:0]         miss;
  logic                              miss_ok;

  logic                              s1_valid;
  logic [r5xor_pkg::FuncW-1:0]       s1_func;
  logic                              s1_inrange;
  logic [AW-1:0]                     s1_addr;
  logic [r5xor_pkg::IdxW-1:0]        s1_idx;
  logic [r5xor_pkg::WordW-1:0]       s1_word;
  logic                              s1_last;
  logic [r5xor_pkg::IdW-1:0]         s1_miss;
  logic                              s1_miss_ok;
  logic [r5xor_pkg::WordW-1:0]       s1_cur;
  logic                              s1_push;

  logic                              wb_valid;
  logic [AW-1:0]                     wb_addr;
  logic [r5xor_pkg::WordW-1:0]       wb_data;

  r5xor_pkg::rsp_item_t              q_mem [QDepth];
  r5xor_pkg::rsp_item_t              q_in;
  logic [QPtrW-1:0]                  q_wr;
  logic [QPtrW-1:0]                  q_rd;
  logic [QCntW-1:0]                  q_cnt;
  logic                              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_chunks <= r5xor_pkg::DATA_CHUNKS_RST;
      chunk_words <= r5xor_pkg::CHUNK_WORDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        r5xor_pkg::CFG_DATA_CHUNKS: data_chunks <= cfg_wdata[r5xor_pkg::KW-1:0];
        r5xor_pkg::CFG_CHUNK_WORDS: chunk_words <= cfg_wdata[r5xor_pkg::CwW-1:0];
        default: ;
      endcase
    end
  end

  assign q_pop     = rsp_valid && rsp_ready;
  assign s1_push   = s1_valid && (s1_func == r5xor_pkg::FUNC_DRAIN);
  assign req_ready = !clearing && ((q_cnt + QCntW'(s1_push)) < QCntW'(QDepth));
  assign accept    = req_valid && req_ready;

  assign req_idx_wide = WideW'(req.word_index);
  assign req_inrange  = req_idx_wide < WideW'(CHUNK_DEPTH);
  assign req_addr     = req_idx_wide[AW-1:0];
  assign req_last     = (chunk_words != '0) &&
                        ({1'b0, req.word_index} == (chunk_words - 1'b1));

  always_comb begin
    seen    = r5xor_pkg::NumIds'(mask);
    miss    = '0;
    miss_ok = 1'b0;
    for (int i = r5xor_pkg::NumIds - 2; i >= 0; i--) begin
      if ((r5xor_pkg::KW'(i) < data_chunks) && !seen[i]) begin
        miss    = r5xor_pkg::IdW'(i);
        miss_ok = 1'b1;
      end
    end
  end

  always_comb begin
    mask_next = mask;
    if (accept) begin
      if (req.func == r5xor_pkg::FUNC_ABSORB) begin
        if (7'(req.chunk_id) < 7'(MAX_CHUNKS)) begin
          mask_next = mask | MaskW'(16'b1 << req.chunk_id);
        end
      end else if (req_last) begin
        mask_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_func    <= req.func;
    s1_inrange <= req_inrange;
    s1_addr    <= req_addr;
    s1_idx     <= req.word_index;
    s1_word    <= req.data_word;
    s1_last    <= req_last;
    s1_miss    <= miss;
    s1_miss_ok <= miss_ok;
  end

  assign s1_cur = (wb_valid && (wb_addr == s1_addr)) ? wb_data : rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = '0;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (s1_valid && s1_inrange) begin
      mem_we    = 1'b1;
      mem_wdata = (s1_func == r5xor_pkg::FUNC_DRAIN) ? '0 : (s1_cur ^ s1_word);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[req_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= mem_we && !clearing;
    end
    wb_addr <= mem_waddr;
    wb_data <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CHUNK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    q_in.result_word   = s1_inrange ? s1_cur : '0;
    q_in.result_index  = s1_idx;
    q_in.last_word     = s1_last;
    q_in.missing_chunk = s1_miss;
    q_in.missing_valid = s1_miss_ok;
  end

  always_ff @(posedge clk) begin
    if (s1_push) begin
      q_mem[q_wr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (s1_push) begin
        q_wr <= q_wr + 1'b1;
      end
      if (q_pop) begin
        q_rd <= q_rd + 1'b1;
      end
      q_cnt <= q_cnt + QCntW'(s1_push) - QCntW'(q_pop);
    end
  end

  assign rsp_valid = (q_cnt != '0);
  assign rsp       = q_mem[q_rd];

  // The buffer sweep after reset must keep every item out.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("item accepted during buffer clear");

  // The result queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= QCntW'(QDepth))
    else $error("result queue overflow");

  // A drained word leaves zero behind in the bypass register.
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_inrange && !clearing && (s1_func == r5xor_pkg::FUNC_DRAIN))
    |=> (wb_valid && (wb_data == '0)))
    else $error("drain did not clear buffer word");

  // Draining the last word of a chunk clears the presence marks.
  a_last_clears_mask: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == r5xor_pkg::FUNC_DRAIN) && req_last) |=> (mask == '0))
    else $error("presence marks kept after last word");

endmodule

`default_nettype wire
